// ===== src/lattice_node_category_classifier_core_macros.svh =====
// Assertion macros used by the checker file.
`ifndef LATTICE_NODE_CATEGORY_CLASSIFIER_CORE_MACROS_SVH
`define LATTICE_NODE_CATEGORY_CLASSIFIER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LNCC_ASSERT_IMP(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is high.
`define LNCC_ASSERT_NXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== src/lncc_pkg.sv =====
package lncc_pkg;

  localparam int MAX_COLUMNS = 10;
  localparam int SET_W       = 10;
  localparam int CAT_W       = 3;
  localparam int OP_W        = 2;
  localparam int CFG_W       = 4;

  localparam int ADDR_W = MAX_COLUMNS;
  localparam int DEPTH  = 1 << ADDR_W;

  // A dependency query walks every mask bit, a non-dependency query every table column.
  localparam int WALK_N = (MAX_COLUMNS > SET_W) ? MAX_COLUMNS : SET_W;
  localparam int IDX_W  = $clog2(WALK_N + 1);
  localparam int CMP_W  = (IDX_W > CFG_W) ? IDX_W : CFG_W;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(10);

  typedef logic [CAT_W-1:0] cat_t;

  localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEP    = 2'd1;
  localparam logic [OP_W-1:0] OP_NONDEP = 2'd2;

  localparam cat_t CAT_UNVISITED       = 3'd0;
  localparam cat_t CAT_CAND_MIN_DEP    = 3'd1;
  localparam cat_t CAT_MIN_DEP         = 3'd2;
  localparam cat_t CAT_DEP             = 3'd3;
  localparam cat_t CAT_CAND_MAX_NONDEP = 3'd4;
  localparam cat_t CAT_MAX_NONDEP      = 3'd5;
  localparam cat_t CAT_NONDEP          = 3'd6;

  typedef struct packed {
    logic capture;
    logic clear;
    logic walk;
    logic load_out;
  } lncc_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic in_query;
    logic walk_done;
    logic out_free;
  } lncc_sts_t;

endpackage

// ===== src/lncc_intf.sv =====
interface lncc_req_if import lncc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [SET_W-1:0] column_set;
  cat_t             category_in;

  modport source (output valid, output op, output column_set, output category_in,
                  input ready);
  modport sink (input valid, input op, input column_set, input category_in,
                output ready);
endinterface

interface lncc_rsp_if import lncc_pkg::*;;
  logic valid;
  logic ready;
  cat_t category_out;

  modport source (output valid, output category_out, input ready);
  modport sink (input valid, input category_out, output ready);
endinterface

// ===== src/lncc_ram.sv =====
module lncc_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/lncc_ctrl.sv =====
module lncc_ctrl import lncc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  lncc_sts_t sts,
  output lncc_cmd_t cmd
);

  typedef enum logic [1:0] {
    CLEAR,
    IDLE,
    WALK,
    DELIVER
  } state_t;

  state_t state;

  assign in_ready     = (state == IDLE);
  assign cmd.capture  = in_valid && in_ready;
  assign cmd.clear    = (state == CLEAR);
  assign cmd.walk     = (state == WALK);
  assign cmd.load_out = (state == DELIVER) && sts.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLEAR;
    end else begin
      unique case (state)
        CLEAR: begin
          if (sts.clear_last) state <= IDLE;
        end
        IDLE: begin
          if (cmd.capture) state <= sts.in_query ? WALK : DELIVER;
        end
        WALK: begin
          if (sts.walk_done) state <= DELIVER;
        end
        DELIVER: begin
          if (sts.out_free) state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/lncc_dp.sv =====
module lncc_dp import lncc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  input  lncc_cmd_t        cmd,
  output lncc_sts_t        sts,
  input  logic [OP_W-1:0]  op,
  input  logic [SET_W-1:0] column_set,
  input  cat_t             category_in,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output cat_t             category_out
);

  logic [CFG_W-1:0]  column_count;
  logic [OP_W-1:0]   op_q;
  logic [WALK_N-1:0] set_q;
  cat_t              res;
  logic [IDX_W-1:0]  idx;
  logic              pend;
  logic [ADDR_W-1:0] clr_addr;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  cat_t              ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  cat_t              ram_rdata;

  logic [WALK_N-1:0] set_in;
  logic [WALK_N-1:0] onehot;
  logic [WALK_N-1:0] probe;
  logic              bit_set;
  logic              idx_end;
  logic              below_cnt;
  logic              is_dep;
  logic              relevant;
  logic              hit_unvisited;
  logic              hit_settled;
  logic              decided;
  cat_t              walk_res;

  assign set_in = WALK_N'(column_set);
  assign onehot = WALK_N'(1) << idx;
  assign probe  = set_q ^ onehot;

  assign bit_set   = |(set_q & onehot);
  assign idx_end   = (idx == IDX_W'(WALK_N));
  assign below_cnt = (CMP_W'(idx) < CMP_W'(column_count)) &&
                     (CMP_W'(idx) < CMP_W'(MAX_COLUMNS));
  assign is_dep    = (op_q == OP_DEP);
  assign relevant  = is_dep ? bit_set : (!bit_set && below_cnt);

  // The read issued for one column is judged from the registered read data, while the next column issues.
  assign hit_unvisited = (ram_rdata == CAT_UNVISITED);
  assign hit_settled   = is_dep ? (ram_rdata == CAT_MIN_DEP || ram_rdata == CAT_DEP)
                                : (ram_rdata == CAT_MAX_NONDEP || ram_rdata == CAT_NONDEP);
  assign decided       = pend && (hit_unvisited || hit_settled);

  always_comb begin
    if (decided) begin
      if (hit_unvisited) walk_res = is_dep ? CAT_CAND_MIN_DEP : CAT_CAND_MAX_NONDEP;
      else               walk_res = is_dep ? CAT_DEP : CAT_NONDEP;
    end else begin
      walk_res = is_dep ? CAT_MIN_DEP : CAT_MAX_NONDEP;
    end
  end

  assign ram_we    = cmd.clear || (cmd.capture && op == OP_WRITE);
  assign ram_waddr = cmd.clear ? clr_addr : set_in[ADDR_W-1:0];
  assign ram_wdata = cmd.clear ? CAT_UNVISITED : category_in;
  assign ram_raddr = probe[ADDR_W-1:0];

  lncc_ram #(
    .WIDTH (CAT_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign sts.clear_last = (clr_addr == ADDR_W'(DEPTH - 1));
  assign sts.in_query   = (op == OP_DEP) || (op == OP_NONDEP);
  assign sts.walk_done  = decided || idx_end;
  assign sts.out_free   = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= CFG_RESET;
      clr_addr     <= '0;
      idx          <= '0;
      pend         <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      if (cfg_we) column_count <= cfg_data;
      if (cmd.clear) clr_addr <= clr_addr + 1'b1;
      if (cmd.capture) begin
        idx  <= '0;
        pend <= 1'b0;
      end else if (cmd.walk && !sts.walk_done) begin
        pend <= relevant;
        idx  <= idx + 1'b1;
      end
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= op;
      set_q <= set_in;
      res   <= (op == OP_WRITE) ? category_in : CAT_UNVISITED;
    end else if (cmd.walk && sts.walk_done) begin
      res <= walk_res;
    end
    if (cmd.load_out) category_out <= res;
  end

endmodule

// ===== src/lattice_node_category_classifier_core.sv =====
// Channel  | Direction | Payload                          | Notes
// req      | in        | op, column_set, category_in      | valid/ready, one item in work
// rsp      | out       | category_out                     | valid/ready, output register
// cfg      | in        | cfg_data (column_count)          | write enable, no read-back
//
// After reset the category store is swept to unvisited, one entry per cycle, over all
// 1024 entries; req.ready stays low until the sweep ends.
// A write or an unused op goes straight from capture to delivery; a query first walks up
// to the ten columns through the single read port of the store, one column per cycle.
// A finished result waits in the output register, so the next request is taken while
// rsp is stalled; only a second finished result waits for that register to drain.
module lattice_node_category_classifier_core import lncc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  lncc_req_if.sink         req,
  lncc_rsp_if.source       rsp
);

  lncc_cmd_t cmd;
  lncc_sts_t sts;

  lncc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lncc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .sts          (sts),
    .op           (req.op),
    .column_set   (req.column_set),
    .category_in  (req.category_in),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .category_out (rsp.category_out)
  );

endmodule

// ===== src/lncc_checker.sv =====
`include "lattice_node_category_classifier_core_macros.svh"

module lncc_checker import lncc_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input cat_t category_out
);

  logic [1:0] pending;
  logic       req_take;
  logic       rsp_take;

  assign req_take = req_valid && req_ready;
  assign rsp_take = rsp_valid && rsp_ready;

  // Requests taken but whose result has not yet been delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (req_take && !rsp_take) begin
      pending <= pending + 1'b1;
    end else if (rsp_take && !req_take) begin
      pending <= pending - 1'b1;
    end
  end

  `LNCC_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(category_out))
  `LNCC_ASSERT_NXT(a_one_in_work, clk, rst, req_take, !req_ready)
  `LNCC_ASSERT_IMP(a_no_invented, clk, rst, rsp_valid, pending != 2'd0)
  `LNCC_ASSERT_IMP(a_ready_room, clk, rst, req_ready, pending < 2'd2)
  `LNCC_ASSERT_IMP(a_sweep_after_reset, clk, rst, $fell(rst), !req_ready && !rsp_valid)

endmodule

bind lattice_node_category_classifier_core lncc_checker u_lncc_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .category_out (rsp.category_out)
);
